// File: design/assert_macros.svh
// assertion macros shared by the positional list store
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the rising clock edge, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on the rising clock edge, also active during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/plst_pkg.sv
// shared types and constants of the positional list store
// no dependencies; used by the decoder, the cells and the top level
package plst_pkg;

    // default sizes
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_ELEM_WIDTH = 32;

    // fixed field widths of the stream ports
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_REAR  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_REAR  = 3'd3,
        CMD_INS_AT    = 3'd4,
        CMD_REM_AT    = 3'd5
    } cmd_e_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } cell_op_t;

    // decoder to cell row and result path
    typedef struct packed {
        cell_op_t op;
        status_t  status;
    } ctrl_t;

endpackage

// File: design/plst_ctrl.sv
// command decoder: checks the command against the fill count
// depends on plst_pkg; drives the cell row and the result path
module plst_ctrl
    import plst_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic [CMD_W-1:0] cmd,
    input  logic [POS_W-1:0] position,
    input  logic [CNT_W-1:0] count,
    output ctrl_t            ctrl,
    output logic [IDX_W-1:0] idx,
    output logic [CNT_W-1:0] count_next
);

    localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] cnt_w;
    logic [WIDE_W-1:0] pos_m1;
    logic [WIDE_W-1:0] cnt_m1;
    logic              empty;
    logic              full;

    assign pos_w  = WIDE_W'(position);
    assign cnt_w  = WIDE_W'(count);
    assign pos_m1 = pos_w - WIDE_W'(1);
    assign cnt_m1 = cnt_w - WIDE_W'(1);
    assign empty  = (count == '0);
    assign full   = (count == CNT_W'(CAPACITY));

    // decode command, pick target index and status
    always_comb
    begin
        ctrl.op     = OP_HOLD;
        ctrl.status = ST_OK;
        idx         = '0;
        case (cmd_e_t'(cmd))
            CMD_ADD_FRONT:
            begin
                if (full)
                    ctrl.status = ST_FULL;
                else
                    ctrl.op = OP_INS;
            end
            CMD_ADD_REAR:
            begin
                idx = cnt_w[IDX_W-1:0];
                if (full)
                    ctrl.status = ST_FULL;
                else
                    ctrl.op = OP_INS;
            end
            CMD_REM_FRONT:
            begin
                if (empty)
                    ctrl.status = ST_UNDER;
                else
                    ctrl.op = OP_REM;
            end
            CMD_REM_REAR:
            begin
                idx = cnt_m1[IDX_W-1:0];
                if (empty)
                    ctrl.status = ST_UNDER;
                else
                    ctrl.op = OP_REM;
            end
            CMD_INS_AT:
            begin
                idx = pos_m1[IDX_W-1:0];
                if (pos_w == '0 || pos_w > cnt_w + WIDE_W'(1))
                    ctrl.status = ST_RANGE;
                else if (full)
                    ctrl.status = ST_FULL;
                else
                    ctrl.op = OP_INS;
            end
            CMD_REM_AT:
            begin
                idx = pos_m1[IDX_W-1:0];
                if (pos_w == '0 || pos_w > cnt_w)
                    ctrl.status = ST_RANGE;
                else
                    ctrl.op = OP_REM;
            end
            default:
            begin
                ctrl.op = OP_HOLD;
            end
        endcase
    end

    // count after the command
    always_comb
    begin
        case (ctrl.op)
            OP_INS:  count_next = count + CNT_W'(1);
            OP_REM:  count_next = count - CNT_W'(1);
            default: count_next = count;
        endcase
    end

endmodule

// File: design/plst_cell.sv
// one storage cell of the list: holds, loads or shifts from a neighbor
// depends on plst_pkg for the cell operation codes
module plst_cell
    import plst_pkg::*;
#(
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [IDX_W-1:0]      idx,
    input  logic [ELEM_WIDTH-1:0] ins_value,
    input  logic [ELEM_WIDTH-1:0] left_entry,
    input  logic [ELEM_WIDTH-1:0] right_entry,
    output logic [ELEM_WIDTH-1:0] entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ELEM_WIDTH-1:0] entry_reg;
    logic [ELEM_WIDTH-1:0] entry_next;

    // insert opens a gap toward the rear, remove closes it toward the front
    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            OP_INS:
            begin
                if (MY_IDX > idx)
                    entry_next = left_entry;
                else if (MY_IDX == idx)
                    entry_next = ins_value;
            end
            OP_REM:
            begin
                if (MY_IDX >= idx)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // element storage, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: design/positional_list_store_unit.sv
// positional list store: the result of an accepted transaction is registered in the
// output register; throughput 1 transaction per cycle, set by the cell row, while no held
// result stalls the input; every cell shifts, loads or holds in the same cycle as the decode.
// rst_n (async, active low) clears the fill count and the output valid;
// element cells are not cleared and are only read below the fill count.
module positional_list_store_unit
    import plst_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [39:0]                    s_axis_tdata,  // position[4:0], value[36:5], zero
    input  logic [CMD_W-1:0]               s_axis_tuser,  // cmd[2:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata   // removed_value[31:0],
                                                          // status[33:32],
                                                          // entry_count[38:34], zero
);

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                  in_fire;
    logic [POS_W-1:0]      position;
    logic [VALUE_W-1:0]    value;
    logic [ELEM_WIDTH-1:0] ins_value;
    ctrl_t                 ctrl;
    cell_op_t              cell_op;
    logic [IDX_W-1:0]      idx;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_dec;
    logic [ELEM_WIDTH-1:0] entries [CAPACITY];
    logic [ELEM_WIDTH-1:0] sel_entry;
    logic [VALUE_W-1:0]    sel_value;
    logic [VALUE_W-1:0]    rem_value;
    logic [COUNT_W-1:0]    count_out;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [39:0]           out_data_reg;
    logic [39:0]           out_data_next;

    // input unpacking and handshake
    assign position      = s_axis_tdata[POS_W-1:0];
    assign value         = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cell_op       = in_fire ? ctrl.op : OP_HOLD;

    // element width adaption on both sides
    generate
        if (ELEM_WIDTH >= VALUE_W)
        begin : g_wide
            assign ins_value = ELEM_WIDTH'(value);
            assign sel_value = sel_entry[VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign ins_value = value[ELEM_WIDTH-1:0];
            assign sel_value = VALUE_W'(sel_entry);
        end
        if (CNT_W >= COUNT_W)
        begin : g_cnt_wide
            assign count_out = count_dec[COUNT_W-1:0];
        end
        else
        begin : g_cnt_narrow
            assign count_out = COUNT_W'(count_dec);
        end
    endgenerate

    // command decode
    plst_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .cmd        (s_axis_tuser),
        .position   (position),
        .count      (count_reg),
        .ctrl       (ctrl),
        .idx        (idx),
        .count_next (count_dec)
    );

    // row of cells, front at index zero
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ELEM_WIDTH-1:0] left_entry;
            logic [ELEM_WIDTH-1:0] right_entry;
            if (gi == 0)
            begin : g_first
                assign left_entry = '0;
            end
            else
            begin : g_mid_l
                assign left_entry = entries[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_mid_r
                assign right_entry = entries[gi+1];
            end
            plst_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .IDX_W      (IDX_W),
                .INDEX      (gi)
            ) u_cell (
                .clk         (clk),
                .op          (cell_op),
                .idx         (idx),
                .ins_value   (ins_value),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entries[gi])
            );
        end
    endgenerate

    // element leaving the list on a remove
    assign sel_entry = entries[idx];
    assign rem_value = (ctrl.op == OP_REM) ? sel_value : '0;

    // fill count and result register
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (in_fire)
        begin
            count_next     = count_dec;
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, count_out, ctrl.status, rem_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks on the count and the result path
    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(CAPACITY),
                "fill count above capacity")
    `ASSERT_CLK(a_rem_dec,
                in_fire && ctrl.op == OP_REM |=> count_reg == $past(count_reg) - CNT_W'(1),
                "remove did not lower the fill count")
    `ASSERT_CLK(a_full_stat, in_fire && ctrl.status == ST_FULL |-> count_reg == CNT_W'(CAPACITY),
                "full status with room left")
    `ASSERT_CLK(a_ready_free, !out_valid_reg |-> s_axis_tready,
                "input stalled with empty result register")

endmodule

// File: test/plst_checker.sv
// result checker for the positional list store: watches both stream channels,
// keeps its own copy of the list and compares every result transaction
// depends on plst_pkg for the command and status codes
`timescale 1ns / 1ps

module plst_checker
    import plst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [39:0]      s_data,   // position[4:0], value[36:5], zero
    input  logic [CMD_W-1:0] s_user,   // cmd[2:0]
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [39:0]      m_data,   // removed_value[31:0], status[33:32],
                                       // entry_count[38:34], zero
    output int               fail_count,
    output int               outstanding
);

    typedef struct packed {
        logic [VALUE_W-1:0] removed;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    // shadow copy of the list, index 0 is the front
    logic [VALUE_W-1:0] shadow_list[$];
    list_result_t       pending_results[$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // apply one command to the shadow list and give the result it must produce
    function automatic list_result_t apply_command(input logic [CMD_W-1:0] code,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VALUE_W-1:0] val);
        list_result_t res;
        int unsigned  fill;
        fill        = shadow_list.size();
        res.removed = '0;
        res.status  = ST_OK;
        case (code)
            CMD_ADD_FRONT, CMD_ADD_REAR:
            begin
                if (fill >= DEF_CAPACITY)
                    res.status = ST_FULL;
                else if (code == CMD_ADD_FRONT)
                    shadow_list.push_front(val);
                else
                    shadow_list.push_back(val);
            end
            CMD_REM_FRONT, CMD_REM_REAR:
            begin
                if (fill == 0)
                    res.status = ST_UNDER;
                else if (code == CMD_REM_FRONT)
                    res.removed = shadow_list.pop_front();
                else
                    res.removed = shadow_list.pop_back();
            end
            CMD_INS_AT:
            begin
                // position check comes ahead of the full check
                if (pos < 1 || pos > fill + 1)
                    res.status = ST_RANGE;
                else if (fill >= DEF_CAPACITY)
                    res.status = ST_FULL;
                else
                    shadow_list.insert(pos - 1, val);
            end
            CMD_REM_AT:
            begin
                if (pos < 1 || pos > fill)
                    res.status = ST_RANGE;
                else
                begin
                    res.removed = shadow_list[pos - 1];
                    shadow_list.delete(pos - 1);
                end
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        res.count = COUNT_W'(shadow_list.size());
        return res;
    endfunction

    // results first: the result register lies between a command and its result, so a result never belongs to
    // the command accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t got;
        if (!rst_n)
        begin
            shadow_list.delete();
            pending_results.delete();
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                got.removed = m_data[31:0];
                got.status  = status_t'(m_data[33:32]);
                got.count   = m_data[38:34];
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result transaction, removed %h status %0d count %0d",
                                 $realtime, got.removed, got.status, got.count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.removed !== want.removed || got.status !== want.status ||
                        got.count !== want.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch, expected removed %h status %0d count %0d, got removed %h status %0d count %0d",
                                     $realtime, want.removed, want.status, want.count,
                                     got.removed, got.status, got.count);
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(apply_command(s_user, s_data[4:0], s_data[36:5]));
        end
        outstanding = pending_results.size();
    end

endmodule

// File: test/tb_top.sv
// top of the positional list store testbench: clock, reset, command stimulus,
// random back-pressure and the final verdict
// depends on plst_pkg, positional_list_store_unit and plst_checker
`timescale 1ns / 1ps

module tb_top;
    import plst_pkg::*;

    // codes with no command behind them
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_COMMANDS = 1920;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int LONG_HOLD       = 300;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [39:0]      s_axis_tdata;   // position[4:0], value[36:5], zero
    logic [CMD_W-1:0] s_axis_tuser;   // cmd[2:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [39:0]      m_axis_tdata;   // removed_value[31:0], status[33:32],
                                      // entry_count[38:34], zero

    int fail_count;
    int outstanding;
    int commands_sent;
    int cycle_count;
    bit sender_steady;
    bit receiver_steady;

    positional_list_store_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    plst_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .s_user      (s_axis_tuser),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // idle length: mostly short, now and then long
    function automatic int idle_length(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // offer one command transaction and wait until it is taken
    task automatic send_command(input logic [CMD_W-1:0] code, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val);
        int idle;
        idle = idle_length(sender_steady);
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, pos};
        s_axis_tuser  <= code;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        commands_sent++;
    endtask

    function automatic logic [CMD_W-1:0] pick_command(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return (r == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
        if (!growing)
            r = 101 - r;
        if (r < 22)
            return CMD_ADD_FRONT;
        else if (r < 46)
            return CMD_ADD_REAR;
        else if (r < 70)
            return CMD_INS_AT;
        else if (r < 80)
            return CMD_REM_FRONT;
        else if (r < 90)
            return CMD_REM_REAR;
        else
            return CMD_REM_AT;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7)
            return 5'd0;
        else if (r < 12)
            return 5'd17;
        else
            return POS_W'($urandom_range(1, 16));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        else
            return $urandom;
    endfunction

    // cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[positional_list_store_unit] ERROR");
        $finish;
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int  stall_left;
        int  phase_left;
        bit  long_done;
        m_axis_tready   = 1'b0;
        receiver_steady = 1'b0;
        stall_left      = 0;
        phase_left      = 0;
        long_done       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                receiver_steady = ($urandom_range(0, 4) == 0);
                phase_left      = $urandom_range(50, 300);
            end
            phase_left--;
            if (!long_done && commands_sent >= 800)
            begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = idle_length(receiver_steady);
            end
        end
    end

    // reset, stimulus and verdict
    initial
    begin
        int  phase_left;
        bit  growing;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ADD_FRONT;
        commands_sent = 0;
        sender_steady = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // starting from an empty list: underflow, out of range, first inserts and spare codes
        send_command(CMD_REM_FRONT, 5'd0, 32'h0);
        send_command(CMD_REM_REAR, 5'd0, 32'h0);
        send_command(CMD_REM_AT, 5'd1, 32'h0);
        send_command(CMD_INS_AT, 5'd0, 32'h1234_5678);
        send_command(CMD_INS_AT, 5'd2, 32'h1234_5678);
        send_command(CMD_INS_AT, 5'd1, 32'h0000_0000);
        send_command(CMD_ADD_FRONT, 5'd0, 32'hFFFF_FFFF);
        send_command(CMD_ADD_REAR, 5'd31, 32'h8000_0001);
        send_command(CMD_SPARE_LO, 5'd1, 32'hDEAD_BEEF);
        send_command(CMD_SPARE_HI, 5'd2, 32'hDEAD_BEEF);
        send_command(CMD_REM_AT, 5'd0, 32'h0);
        send_command(CMD_REM_AT, 5'd4, 32'h0);
        send_command(CMD_INS_AT, 5'd4, 32'h5555_AAAA);
        // fill up to capacity
        for (int i = 0; i < 12; i++)
            send_command((i % 3 == 0) ? CMD_ADD_FRONT : CMD_ADD_REAR, 5'd0, 32'hA5A5_0000 + i);
        // full list: add, insert at the end slot, bad position wins over full, then two removes by position
        send_command(CMD_ADD_FRONT, 5'd0, 32'h0BAD_0BAD);
        send_command(CMD_INS_AT, 5'd17, 32'h0BAD_0BAD);
        send_command(CMD_INS_AT, 5'd0, 32'h0BAD_0BAD);
        send_command(CMD_REM_AT, 5'd16, 32'h0);
        send_command(CMD_REM_AT, 5'd7, 32'h0);

        // random part: phases that lean toward growing or shrinking the list
        phase_left = 0;
        growing    = 1'b1;
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (phase_left == 0)
            begin
                growing       = ~growing;
                phase_left    = $urandom_range(20, 80);
                sender_steady = ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            send_command(pick_command(growing), pick_position(), pick_value());
        end
        s_axis_tvalid <= 1'b0;

        // drain the results still owed
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[positional_list_store_unit] OK");
        else
            $display("[positional_list_store_unit] ERROR");
        $finish;
    end

endmodule
